// File: src/jss_pkg.sv
package jss_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register field widths
  localparam int SIZE_W   = 11;
  localparam int GAIN_W   = 18;
  localparam int OFFSET_W = 32;

  // Fixed-point layout: cells Q16.16, gains Q2.16
  localparam int FRAC_BITS = 16;

  // Smallest grid edge that still has an interior
  localparam int MIN_SIZE = 3;

  // Columns held in the stencil window
  localparam int WINDOW = 3;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_GAIN_VERTICAL,
    CFG_GAIN_HORIZONTAL,
    CFG_SOURCE_OFFSET
  } cfg_reg_t;

  // Input opcodes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Register reset values
  localparam logic [SIZE_W-1:0]   GRID_WIDTH_RESET  = 11'd10;
  localparam logic [SIZE_W-1:0]   GRID_HEIGHT_RESET = 11'd20;
  localparam logic [GAIN_W-1:0]   GAIN_RESET        = 18'd16384;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET      = 32'd0;

  // Per-result control carried alongside the data path
  typedef struct packed {
    logic valid;
    logic boundary;
    logic last;
  } meta_t;

endpackage

// File: src/jss_cell.sv
module jss_cell #(
  parameter int CELL_BITS = 32
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic signed [CELL_BITS-1:0] up_in,
  input  logic signed [CELL_BITS-1:0] mid_in,
  input  logic signed [CELL_BITS-1:0] dn_in,
  output logic signed [CELL_BITS-1:0] up,
  output logic signed [CELL_BITS-1:0] mid,
  output logic signed [CELL_BITS-1:0] dn
);

  // Take the window column from the neighbor on each shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      up  <= up_in;
      mid <= mid_in;
      dn  <= dn_in;
    end
  end

endmodule

// File: src/jss_line_buf.sv
module jss_line_buf #(
  parameter int CELL_BITS = 32,
  parameter int DEPTH     = 1024
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic                        wr_en,
  input  logic signed [CELL_BITS-1:0] wr_data,
  output logic signed [CELL_BITS-1:0] up_data,
  output logic signed [CELL_BITS-1:0] mid_data
);

  localparam int ADDR_W = $clog2(DEPTH);

  // Row before the current one, and the row before that
  logic signed [CELL_BITS-1:0] prev_row  [DEPTH];
  logic signed [CELL_BITS-1:0] prev2_row [DEPTH];
  logic [ADDR_W-1:0]           addr_q;

  // Read both rows at the column of the arriving item; write back one item
  // later at the held address, moving the older row down by one
  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= addr;
      mid_data <= prev_row[addr];
      up_data  <= prev2_row[addr];
    end
    if (wr_en) begin
      prev_row[addr_q]  <= wr_data;
      prev2_row[addr_q] <= mid_data;
    end
  end

endmodule

// File: src/jss_stencil.sv
module jss_stencil #(
  parameter int CELL_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  jss_pkg::meta_t                     meta_in,
  input  logic signed [CELL_BITS-1:0]        up,
  input  logic signed [CELL_BITS-1:0]        dn,
  input  logic signed [CELL_BITS-1:0]        lf,
  input  logic signed [CELL_BITS-1:0]        rt,
  input  logic signed [CELL_BITS-1:0]        center,
  input  logic [jss_pkg::GAIN_W-1:0]         gain_v,
  input  logic [jss_pkg::GAIN_W-1:0]         gain_h,
  input  logic signed [jss_pkg::OFFSET_W-1:0] offset,
  output logic                               result_valid,
  output logic signed [CELL_BITS-1:0]        new_value,
  output logic                               boundary_cell,
  output logic                               saturated,
  output logic                               last_of_grid
);

  localparam int SUM_W  = CELL_BITS + 1;
  localparam int PW     = SUM_W + jss_pkg::GAIN_W + 1;
  localparam int TW     = PW + 1 - jss_pkg::FRAC_BITS;
  localparam int RW     = ((TW > jss_pkg::OFFSET_W) ? TW : jss_pkg::OFFSET_W) + 1;
  localparam logic signed [PW:0] ROUND_HALF = (PW + 1)'(1) << (jss_pkg::FRAC_BITS - 1);
  localparam logic [CELL_BITS-1:0] CELL_MAX = {1'b0, {(CELL_BITS - 1){1'b1}}};
  localparam logic [CELL_BITS-1:0] CELL_MIN = {1'b1, {(CELL_BITS - 1){1'b0}}};

  jss_pkg::meta_t              s3_meta, s4_meta, s5_meta;
  logic signed [SUM_W-1:0]     s3_sv, s3_sh;
  logic signed [CELL_BITS-1:0] s3_center, s4_center, s5_center;
  logic signed [PW-1:0]        s4_pv, s4_ph;
  logic signed [TW-1:0]        s5_t;

  logic signed [jss_pkg::GAIN_W:0] gv_s, gh_s;
  logic signed [PW:0]              acc;
  logic signed [RW-1:0]            diff;
  logic                            ovf;
  logic [CELL_BITS-1:0]            clipped;

  assign gv_s = {1'b0, gain_v};
  assign gh_s = {1'b0, gain_h};

  // Round to Q16.16: add one half, then floor
  assign acc = s4_pv + s4_ph + ROUND_HALF;

  // Subtract the source term and clip to the cell range
  assign diff = {{(RW - TW){s5_t[TW-1]}}, s5_t}
              - {{(RW - jss_pkg::OFFSET_W){offset[jss_pkg::OFFSET_W-1]}}, offset};
  assign ovf  = !((&diff[RW-1:CELL_BITS-1]) || (~|diff[RW-1:CELL_BITS-1]));

  always_comb begin
    if (ovf) begin
      clipped = diff[RW-1] ? CELL_MIN : CELL_MAX;
    end else begin
      clipped = diff[CELL_BITS-1:0];
    end
  end

  // Advance the control of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_meta      <= '0;
      s4_meta      <= '0;
      s5_meta      <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s3_meta      <= meta_in;
      s4_meta      <= s3_meta;
      s5_meta      <= s4_meta;
      result_valid <= s5_meta.valid;
    end
  end

  // Neighbor sums, weighted products, rounding, then the output item
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sv         <= {up[CELL_BITS-1], up} + {dn[CELL_BITS-1], dn};
      s3_sh         <= {lf[CELL_BITS-1], lf} + {rt[CELL_BITS-1], rt};
      s3_center     <= center;
      s4_pv         <= s3_sv * gv_s;
      s4_ph         <= s3_sh * gh_s;
      s4_center     <= s3_center;
      s5_t          <= acc[PW:jss_pkg::FRAC_BITS];
      s5_center     <= s4_center;
      new_value     <= s5_meta.boundary ? s5_center : clipped;
      boundary_cell <= s5_meta.boundary;
      saturated     <= !s5_meta.boundary && ovf;
      last_of_grid  <= s5_meta.last;
    end
  end

  a_last_is_edge: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_grid |-> boundary_cell && !saturated)
    else $error("final item of the sweep is not a boundary cell");

  a_sat_interior: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) && saturated |-> !boundary_cell)
    else $error("boundary cell flagged as saturated");

endmodule

// File: src/jacobi_stencil_sweep.sv
// Jacobi five-point stencil, one sweep over a grid streamed in raster order.
//
// Input channel (cell_valid / cell_stall): opcode 0 carries one grid cell,
// opcode 1 is a drain item. Output channel (result_valid / result_stall)
// gives the updated cells in raster order. A cell's result is released by
// the item that arrives grid_width+1 items after it; after the last cell,
// grid_width+1 drain items flush the tail. Cells past the end of the grid and
// drain items sent early are dropped without a result.
// Throughput is one item per cycle while the receiver does not stall: each
// item does one read and one write on each of two row memories at different
// columns, and the window moves by one column per item. An item's result,
// when it has one, passes the registered steps memory read, window, sums,
// products, rounding and clipping before it shows on the output.
// When the receiver stalls a valid output item, the whole pipeline holds and
// cell_stall is high; the held output item does not change.
// Reset clears the position counters and loads the register defaults; the
// row memories are not cleared, since every entry is written before use.
// Writing grid_width or grid_height restarts the sweep at row 0, column 0.
module jacobi_stencil_sweep #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CELL_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [jss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [jss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  logic                                opcode,
  input  logic signed [CELL_BITS-1:0]         cell_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [CELL_BITS-1:0]         new_value,
  output logic                                boundary_cell,
  output logic                                saturated,
  output logic                                last_of_grid
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);

  function automatic int clamp_size(input logic [jss_pkg::SIZE_W-1:0] v, input int hi);
    int vi;
    vi = int'(v);
    if (vi < jss_pkg::MIN_SIZE) begin
      return jss_pkg::MIN_SIZE;
    end else if (vi > hi) begin
      return hi;
    end
    return vi;
  endfunction

  // Configuration
  logic [WCNT_W-1:0]                  w_eff;
  logic [COL_W-1:0]                   w_last;
  logic [ROW_W-1:0]                   h_eff;
  logic [OROW_W-1:0]                  h_last;
  logic [jss_pkg::GAIN_W-1:0]         gain_vertical;
  logic [jss_pkg::GAIN_W-1:0]         gain_horizontal;
  logic signed [jss_pkg::OFFSET_W-1:0] source_offset;
  int                                 w_cfg, h_cfg;
  logic                               restart;

  // Position counters
  logic [WCNT_W-1:0] in_column, in_column_next, in_column_inc;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]  out_column, out_column_next;
  logic [OROW_W-1:0] out_row, out_row_next;

  // Item control
  logic           adv, accept, is_drain, grid_full;
  logic           take_cell, take_drain, push, produce, bnd, last;
  jss_pkg::meta_t meta_next, s1_meta, s2_meta;
  logic           s1_push, s1_is_cell;
  logic signed [CELL_BITS-1:0] s1_x;

  // Window columns: entry 0 feeds the chain, entry k+1 is cell k
  logic signed [CELL_BITS-1:0] col_up  [jss_pkg::WINDOW+1];
  logic signed [CELL_BITS-1:0] col_mid [jss_pkg::WINDOW+1];
  logic signed [CELL_BITS-1:0] col_dn  [jss_pkg::WINDOW+1];

  assign w_cfg = clamp_size(cfg_data[jss_pkg::SIZE_W-1:0], MAX_WIDTH);
  assign h_cfg = clamp_size(cfg_data[jss_pkg::SIZE_W-1:0], MAX_HEIGHT);
  assign restart = cfg_write && (cfg_index == jss_pkg::CFG_GRID_WIDTH ||
                                 cfg_index == jss_pkg::CFG_GRID_HEIGHT);

  // Hold the register file; sizes are stored clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff           <= WCNT_W'(clamp_size(jss_pkg::GRID_WIDTH_RESET, MAX_WIDTH));
      w_last          <= COL_W'(clamp_size(jss_pkg::GRID_WIDTH_RESET, MAX_WIDTH) - 1);
      h_eff           <= ROW_W'(clamp_size(jss_pkg::GRID_HEIGHT_RESET, MAX_HEIGHT));
      h_last          <= OROW_W'(clamp_size(jss_pkg::GRID_HEIGHT_RESET, MAX_HEIGHT) - 1);
      gain_vertical   <= jss_pkg::GAIN_RESET;
      gain_horizontal <= jss_pkg::GAIN_RESET;
      source_offset   <= jss_pkg::OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        jss_pkg::CFG_GRID_WIDTH: begin
          w_eff  <= WCNT_W'(w_cfg);
          w_last <= COL_W'(w_cfg - 1);
        end
        jss_pkg::CFG_GRID_HEIGHT: begin
          h_eff  <= ROW_W'(h_cfg);
          h_last <= OROW_W'(h_cfg - 1);
        end
        jss_pkg::CFG_GAIN_VERTICAL:   gain_vertical   <= cfg_data[jss_pkg::GAIN_W-1:0];
        jss_pkg::CFG_GAIN_HORIZONTAL: gain_horizontal <= cfg_data[jss_pkg::GAIN_W-1:0];
        jss_pkg::CFG_SOURCE_OFFSET:   source_offset   <= cfg_data[jss_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or not stalled
  assign adv        = !(result_valid && result_stall);
  assign cell_stall = !adv;
  assign accept     = cell_valid && adv;

  // Classify the item against the grid position
  assign is_drain   = (opcode == jss_pkg::OP_DRAIN);
  assign grid_full  = (in_row >= h_eff);
  assign take_cell  = accept && !is_drain && !grid_full;
  assign take_drain = accept && is_drain && grid_full;
  assign push       = take_cell || take_drain;
  assign produce    = take_drain ||
                      (take_cell && (in_row >= ROW_W'(2) ||
                                     (in_row == ROW_W'(1) && in_column != '0)));
  assign bnd        = take_drain || out_row == '0 || out_row == h_last ||
                      out_column == '0 || out_column == w_last;
  assign last       = (out_row == h_last) && (out_column == w_last);
  assign meta_next  = '{valid: produce, boundary: bnd, last: last};
  assign in_column_inc = in_column + 1'b1;

  // Advance input and output positions; restart after the final result or on a size write
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (take_cell) begin
      if (in_column_inc >= w_eff) begin
        in_column_next = '0;
        in_row_next    = in_row + 1'b1;
      end else begin
        in_column_next = in_column_inc;
      end
    end else if (take_drain) begin
      in_column_next = in_column_inc;
    end
    if (produce) begin
      if (last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else if (out_column == w_last) begin
        out_column_next = '0;
        out_row_next    = out_row + 1'b1;
      end else begin
        out_column_next = out_column + 1'b1;
      end
    end
    if (restart) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Stage 1 sits beside the row memory read; stage 2 beside the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_push <= 1'b0;
      s1_meta <= '0;
      s2_meta <= '0;
    end else if (adv) begin
      s1_push <= push;
      s1_meta <= meta_next;
      s2_meta <= s1_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_is_cell <= !is_drain;
      s1_x       <= cell_value;
    end
  end

  jss_line_buf #(
    .CELL_BITS (CELL_BITS),
    .DEPTH     (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (push),
    .addr     (in_column[COL_W-1:0]),
    .wr_en    (adv && s1_push && s1_is_cell),
    .wr_data  (s1_x),
    .up_data  (col_up[0]),
    .mid_data (col_mid[0])
  );

  assign col_dn[0] = s1_x;

  // Sliding window: one column enters per item
  for (genvar k = 0; k < jss_pkg::WINDOW; k++) begin : g_window
    jss_cell #(
      .CELL_BITS (CELL_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (adv && s1_push),
      .up_in    (col_up[k]),
      .mid_in   (col_mid[k]),
      .dn_in    (col_dn[k]),
      .up       (col_up[k+1]),
      .mid      (col_mid[k+1]),
      .dn       (col_dn[k+1])
    );
  end

  jss_stencil #(
    .CELL_BITS (CELL_BITS)
  ) u_stencil (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .meta_in       (s2_meta),
    .up            (col_up[2]),
    .dn            (col_dn[2]),
    .lf            (col_mid[3]),
    .rt            (col_mid[1]),
    .center        (col_mid[2]),
    .gain_v        (gain_vertical),
    .gain_h        (gain_horizontal),
    .offset        (source_offset),
    .result_valid  (result_valid),
    .new_value     (new_value),
    .boundary_cell (boundary_cell),
    .saturated     (saturated),
    .last_of_grid  (last_of_grid)
  );

  a_in_row_range: assert property (@(posedge clk) disable iff (rst)
    in_row <= h_eff && in_column <= w_eff)
    else $error("input position beyond the grid");

  a_out_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_column <= w_last && out_row <= h_last)
    else $error("output position beyond the grid");

endmodule
